/* src/thse_pkg.sv */
// Shared constants, types and saturating helpers for the triangle strain energy block.
// Depends on nothing; every other file but thse_chk refers to it by scoped names.
package thse_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QSHIFT    = 32 - FRAC_BITS;
    localparam int QB        = 63 - QSHIFT;
    localparam int NUM_W     = 62;
    localparam int DEN_W     = 32;
    localparam int DIV_BITS  = 4;
    localparam int DIV_ST    = (QB + DIV_BITS - 1) / DIV_BITS;
    localparam int MUL_LAT   = 4;

    localparam int ST_SQ   = 1;
    localparam int ST_DI   = 2;
    localparam int ST_RT   = ST_DI + DIV_ST + 1;
    localparam int ST_L1   = ST_RT + MUL_LAT;
    localparam int ST_L2   = ST_L1 + MUL_LAT;
    localparam int ST_SB   = ST_L2 + 1;
    localparam int ST_L3   = ST_SB + MUL_LAT;
    localparam int ST_L4   = ST_L3 + MUL_LAT;
    localparam int ST_A1   = ST_L4 + 1;
    localparam int ST_A2   = ST_A1 + 1;
    localparam int ST_L5   = ST_A2 + MUL_LAT;
    localparam int ST_E1   = ST_L5 + 1;
    localparam int ST_E2   = ST_E1 + 1;
    localparam int ST_LAST = ST_E2;

    localparam int MI_L1 = 0;
    localparam int MI_L2 = 9;
    localparam int MI_L3 = 21;
    localparam int MI_L4 = 27;
    localparam int MI_L5 = 36;
    localparam int N_MUL = 39;

    typedef logic signed [63:0] t_q64;
    typedef logic [5:0][63:0] t_mat6;

    typedef struct packed {
        logic [31:0] area;
        logic [31:0] cot_i;
        logic [31:0] cot_j;
        logic [31:0] cot_k;
        logic [31:0] dll_ij;
        logic [31:0] dll_jk;
        logic [31:0] dll_ki;
    } t_side;

    typedef struct packed {
        logic sat;
        t_q64 val;
    } t_sat_q;

    localparam t_q64 Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_q64 Q_MIN  = 64'sh8000_0000_0000_0000;
    localparam t_q64 Q_FOUR = 64'sh0000_0004_0000_0000;
    localparam t_q64 Q_TWO  = 64'sh0000_0002_0000_0000;

    function automatic t_q64 to_q32(input logic [31:0] v);
        return {{(32 - QSHIFT){v[31]}}, v, {QSHIFT{1'b0}}};
    endfunction

    function automatic t_sat_q sat_add(input t_q64 a, input t_q64 b);
        t_sat_q r;
        t_q64   s;
        s     = a + b;
        r.sat = (a[63] == b[63]) && (s[63] != a[63]);
        r.val = r.sat ? (a[63] ? Q_MIN : Q_MAX) : s;
        return r;
    endfunction

    function automatic t_sat_q sat_sub(input t_q64 a, input t_q64 b);
        t_sat_q r;
        t_q64   s;
        s     = a - b;
        r.sat = (a[63] != b[63]) && (s[63] != a[63]);
        r.val = r.sat ? (a[63] ? Q_MIN : Q_MAX) : s;
        return r;
    endfunction

endpackage

/* src/triangle_hencky_strain_energy.sv */
// Throughput one item per cycle while the result is not stalled.
// Depth is set by the 12-stage restoring divider (4 quotient bits per stage) and five
// layers of 4-stage multipliers. A stalled result freezes the whole pipeline.
// Reset (synchronous, active low) clears all valid bits and loads zero_area_ratio
// with its maximum; no clearing pass. Depends on thse_pkg and thse_mul.
module triangle_hencky_strain_energy (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_face_area,
    input  logic [30:0]        i_len_ij,
    input  logic [30:0]        i_len_jk,
    input  logic [30:0]        i_len_ki,
    input  logic signed [31:0] i_cot_i,
    input  logic signed [31:0] i_cot_j,
    input  logic signed [31:0] i_cot_k,
    input  logic signed [31:0] i_dll_ij,
    input  logic signed [31:0] i_dll_jk,
    input  logic signed [31:0] i_dll_ki,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_energy,
    output logic signed [63:0] o_m_ij,
    output logic signed [63:0] o_m_jk,
    output logic signed [63:0] o_m_ki,
    output logic signed [63:0] o_m_i,
    output logic signed [63:0] o_m_j,
    output logic signed [63:0] o_m_k,
    output logic               o_overflow
);

    localparam int QB = thse_pkg::QB;
    localparam int DS = thse_pkg::DIV_ST;
    localparam int NW = thse_pkg::NUM_W;
    localparam int SL = thse_pkg::ST_LAST;

    logic                 en;
    logic [30:0]          r_zar;
    logic [SL:0]          r_vld;
    logic [SL:0]          r_flg;
    logic [SL:0]          n_flg;
    logic [SL:0]          f_in;
    thse_pkg::t_side      r_side [0:thse_pkg::ST_A2];
    logic [30:0]          r_len [0:2];
    logic [NW-1:0]        r_num [0:5];
    logic [31:0]          r_den0;
    logic                 r_pos0;
    logic [31:0]          r_rem [0:DS][0:5];
    logic [QB-1:0]        r_w   [0:DS][0:5];
    logic [31:0]          n_rem [1:DS][0:5];
    logic [QB-1:0]        n_w   [1:DS][0:5];
    logic [31:0]          r_den [0:DS];
    logic [5:0]           r_dsat [0:DS];
    logic                 r_pos [0:DS];
    thse_pkg::t_q64       r_rat [0:5];
    thse_pkg::t_q64       n_rat [0:5];
    logic                 rat_sat;
    thse_pkg::t_q64       mul_x [0:thse_pkg::N_MUL-1];
    thse_pkg::t_q64       mul_y [0:thse_pkg::N_MUL-1];
    thse_pkg::t_q64       mul_p [0:thse_pkg::N_MUL-1];
    logic [thse_pkg::N_MUL-1:0] mul_sat;
    thse_pkg::t_sat_q     sub_r [0:5];
    logic                 sub_sat;
    thse_pkg::t_q64       r_t [0:5];
    thse_pkg::t_q64       r_s [0:5];
    thse_pkg::t_sat_q     add1 [0:2];
    thse_pkg::t_sat_q     add2 [0:2];
    logic                 a1_sat, a2_sat;
    thse_pkg::t_q64       r_v1 [0:2];
    thse_pkg::t_q64       r_p3 [0:2];
    thse_pkg::t_q64       r_v [0:2];
    thse_pkg::t_sat_q     e1_r, e2_r;
    thse_pkg::t_q64       r_e1, r_e2, r_en;
    thse_pkg::t_mat6      r_mdl [thse_pkg::ST_L3+1:SL];

    assign en          = !(r_vld[SL] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[SL];
    assign o_energy    = r_en;
    assign o_m_ij      = r_mdl[SL][0];
    assign o_m_jk      = r_mdl[SL][1];
    assign o_m_ki      = r_mdl[SL][2];
    assign o_m_i       = r_mdl[SL][3];
    assign o_m_j       = r_mdl[SL][4];
    assign o_m_k       = r_mdl[SL][5];
    assign o_overflow  = r_flg[SL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zar <= 31'h7FFF_FFFF;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) begin
                r_zar <= i_cfg_data;
            end
            if (en) begin
                r_vld <= {r_vld[SL-1:0], i_in_valid};
            end
        end
    end

    // divider steps: shift in one numerator bit, subtract when it fits
    always_comb begin
        logic [31:0]   rem;
        logic [QB-1:0] w;
        logic [32:0]   t;
        logic [32:0]   t2;
        logic          ge;
        for (int j = 1; j <= DS; j++) begin
            for (int d = 0; d < 6; d++) begin
                rem = r_rem[j-1][d];
                w   = r_w[j-1][d];
                for (int k = 0; k < thse_pkg::DIV_BITS; k++) begin
                    if ((j - 1) * thse_pkg::DIV_BITS + k < QB) begin
                        t   = {rem, w[QB-1]};
                        t2  = t - {1'b0, r_den[j-1]};
                        ge  = t >= {1'b0, r_den[j-1]};
                        rem = ge ? t2[31:0] : t[31:0];
                        w   = {w[QB-2:0], ge};
                    end
                end
                n_rem[j][d] = rem;
                n_w[j][d]   = w;
            end
        end
    end

    always_comb begin
        for (int d = 0; d < 6; d++) begin
            if (!r_pos[DS]) begin
                n_rat[d] = 64'(r_zar) << thse_pkg::QSHIFT;
            end else if (r_dsat[DS][d]) begin
                n_rat[d] = thse_pkg::Q_MAX;
            end else begin
                n_rat[d] = {1'b0, r_w[DS][d], {thse_pkg::QSHIFT{1'b0}}};
            end
        end
        rat_sat = r_pos[DS] & (|r_dsat[DS]);
    end

    always_comb begin
        for (int d = 0; d < 6; d++) begin
            mul_x[thse_pkg::MI_L1+d] = r_rat[d];
            mul_y[thse_pkg::MI_L1+d] = r_rat[d];
        end
        mul_x[thse_pkg::MI_L1+6] = thse_pkg::Q_FOUR;
        mul_y[thse_pkg::MI_L1+6] = thse_pkg::to_q32(r_side[thse_pkg::ST_RT].cot_j);
        mul_x[thse_pkg::MI_L1+7] = thse_pkg::Q_FOUR;
        mul_y[thse_pkg::MI_L1+7] = thse_pkg::to_q32(r_side[thse_pkg::ST_RT].cot_k);
        mul_x[thse_pkg::MI_L1+8] = thse_pkg::Q_FOUR;
        mul_y[thse_pkg::MI_L1+8] = thse_pkg::to_q32(r_side[thse_pkg::ST_RT].cot_i);

        for (int d = 0; d < 6; d++) begin
            mul_x[thse_pkg::MI_L2+d] = thse_pkg::to_q32(r_side[thse_pkg::ST_L1].area);
            mul_y[thse_pkg::MI_L2+d] = mul_p[thse_pkg::MI_L1+d];
        end
        mul_x[thse_pkg::MI_L2+6]  = thse_pkg::Q_FOUR;
        mul_y[thse_pkg::MI_L2+6]  = mul_p[thse_pkg::MI_L1+5];
        mul_x[thse_pkg::MI_L2+7]  = thse_pkg::Q_FOUR;
        mul_y[thse_pkg::MI_L2+7]  = mul_p[thse_pkg::MI_L1+3];
        mul_x[thse_pkg::MI_L2+8]  = thse_pkg::Q_FOUR;
        mul_y[thse_pkg::MI_L2+8]  = mul_p[thse_pkg::MI_L1+4];
        mul_x[thse_pkg::MI_L2+9]  = mul_p[thse_pkg::MI_L1+6];
        mul_y[thse_pkg::MI_L2+9]  = thse_pkg::to_q32(r_side[thse_pkg::ST_L1].cot_k);
        mul_x[thse_pkg::MI_L2+10] = mul_p[thse_pkg::MI_L1+7];
        mul_y[thse_pkg::MI_L2+10] = thse_pkg::to_q32(r_side[thse_pkg::ST_L1].cot_i);
        mul_x[thse_pkg::MI_L2+11] = mul_p[thse_pkg::MI_L1+8];
        mul_y[thse_pkg::MI_L2+11] = thse_pkg::to_q32(r_side[thse_pkg::ST_L1].cot_j);

        for (int d = 0; d < 6; d++) begin
            mul_x[thse_pkg::MI_L3+d] = r_t[d];
            mul_y[thse_pkg::MI_L3+d] = r_s[d];
        end

        // row products: matrix order ij, jk, ki, i, j, k
        mul_x[thse_pkg::MI_L4+0] = mul_p[thse_pkg::MI_L3+0];
        mul_x[thse_pkg::MI_L4+1] = mul_p[thse_pkg::MI_L3+4];
        mul_x[thse_pkg::MI_L4+2] = mul_p[thse_pkg::MI_L3+3];
        mul_x[thse_pkg::MI_L4+3] = mul_p[thse_pkg::MI_L3+4];
        mul_x[thse_pkg::MI_L4+4] = mul_p[thse_pkg::MI_L3+1];
        mul_x[thse_pkg::MI_L4+5] = mul_p[thse_pkg::MI_L3+5];
        mul_x[thse_pkg::MI_L4+6] = mul_p[thse_pkg::MI_L3+3];
        mul_x[thse_pkg::MI_L4+7] = mul_p[thse_pkg::MI_L3+5];
        mul_x[thse_pkg::MI_L4+8] = mul_p[thse_pkg::MI_L3+2];
        for (int i = 0; i < 3; i++) begin
            mul_y[thse_pkg::MI_L4+3*i]   = thse_pkg::to_q32(r_side[thse_pkg::ST_L3].dll_ij);
            mul_y[thse_pkg::MI_L4+3*i+1] = thse_pkg::to_q32(r_side[thse_pkg::ST_L3].dll_jk);
            mul_y[thse_pkg::MI_L4+3*i+2] = thse_pkg::to_q32(r_side[thse_pkg::ST_L3].dll_ki);
        end

        mul_x[thse_pkg::MI_L5+0] = thse_pkg::to_q32(r_side[thse_pkg::ST_A2].dll_ij);
        mul_x[thse_pkg::MI_L5+1] = thse_pkg::to_q32(r_side[thse_pkg::ST_A2].dll_jk);
        mul_x[thse_pkg::MI_L5+2] = thse_pkg::to_q32(r_side[thse_pkg::ST_A2].dll_ki);
        for (int i = 0; i < 3; i++) begin
            mul_y[thse_pkg::MI_L5+i] = r_v[i];
        end
    end

    for (genvar g = 0; g < thse_pkg::N_MUL; g++) begin : g_mul
        thse_mul u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_x   (mul_x[g]),
            .i_y   (mul_y[g]),
            .o_p   (mul_p[g]),
            .o_sat (mul_sat[g])
        );
    end

    always_comb begin
        sub_sat = 1'b0;
        for (int d = 0; d < 6; d++) begin
            sub_r[d] = thse_pkg::sat_sub(mul_p[thse_pkg::MI_L2+6+d], thse_pkg::Q_TWO);
            sub_sat  = sub_sat | sub_r[d].sat;
        end
        a1_sat = 1'b0;
        a2_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            add1[i] = thse_pkg::sat_add(mul_p[thse_pkg::MI_L4+3*i],
                                        mul_p[thse_pkg::MI_L4+3*i+1]);
            add2[i] = thse_pkg::sat_add(r_v1[i], r_p3[i]);
            a1_sat  = a1_sat | add1[i].sat;
            a2_sat  = a2_sat | add2[i].sat;
        end
        e1_r = thse_pkg::sat_add(mul_p[thse_pkg::MI_L5], mul_p[thse_pkg::MI_L5+1]);
        e2_r = thse_pkg::sat_add(r_e1, r_e2);
    end

    always_comb begin
        n_flg = r_flg;
        n_flg[thse_pkg::ST_L1] = r_flg[thse_pkg::ST_L1]
                                 | (|mul_sat[thse_pkg::MI_L2-1:thse_pkg::MI_L1]);
        n_flg[thse_pkg::ST_L2] = r_flg[thse_pkg::ST_L2]
                                 | (|mul_sat[thse_pkg::MI_L3-1:thse_pkg::MI_L2]);
        n_flg[thse_pkg::ST_L3] = r_flg[thse_pkg::ST_L3]
                                 | (|mul_sat[thse_pkg::MI_L4-1:thse_pkg::MI_L3]);
        n_flg[thse_pkg::ST_L4] = r_flg[thse_pkg::ST_L4]
                                 | (|mul_sat[thse_pkg::MI_L5-1:thse_pkg::MI_L4]);
        n_flg[thse_pkg::ST_L5] = r_flg[thse_pkg::ST_L5]
                                 | (|mul_sat[thse_pkg::N_MUL-1:thse_pkg::MI_L5]);
        f_in = {n_flg[SL-1:0], 1'b0};
        f_in[thse_pkg::ST_RT] = n_flg[thse_pkg::ST_RT-1] | rat_sat;
        f_in[thse_pkg::ST_SB] = n_flg[thse_pkg::ST_SB-1] | sub_sat;
        f_in[thse_pkg::ST_A1] = n_flg[thse_pkg::ST_A1-1] | a1_sat;
        f_in[thse_pkg::ST_A2] = n_flg[thse_pkg::ST_A2-1] | a2_sat;
        f_in[thse_pkg::ST_E1] = n_flg[thse_pkg::ST_E1-1] | e1_r.sat;
        f_in[thse_pkg::ST_E2] = n_flg[thse_pkg::ST_E2-1] | e2_r.sat;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flg     <= f_in;
            r_side[0] <= {i_face_area, i_cot_i, i_cot_j, i_cot_k, i_dll_ij, i_dll_jk, i_dll_ki};
            for (int s = 1; s <= thse_pkg::ST_A2; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_len[0] <= i_len_ij;
            r_len[1] <= i_len_jk;
            r_len[2] <= i_len_ki;

            r_num[0] <= r_len[0] * r_len[0];
            r_num[1] <= r_len[1] * r_len[1];
            r_num[2] <= r_len[2] * r_len[2];
            r_num[3] <= r_len[0] * r_len[2];
            r_num[4] <= r_len[1] * r_len[0];
            r_num[5] <= r_len[2] * r_len[1];
            r_den0   <= {r_side[0].area[30:0], 1'b0};
            r_pos0   <= !r_side[0].area[31] && (|r_side[0].area[30:0]);

            for (int d = 0; d < 6; d++) begin
                r_rem[0][d]  <= 32'(r_num[d][NW-1:QB]);
                r_w[0][d]    <= r_num[d][QB-1:0];
                r_dsat[0][d] <= 32'(r_num[d][NW-1:QB]) >= r_den0;
            end
            r_den[0] <= r_den0;
            r_pos[0] <= r_pos0;
            for (int j = 1; j <= DS; j++) begin
                for (int d = 0; d < 6; d++) begin
                    r_rem[j][d] <= n_rem[j][d];
                    r_w[j][d]   <= n_w[j][d];
                end
                r_den[j]  <= r_den[j-1];
                r_dsat[j] <= r_dsat[j-1];
                r_pos[j]  <= r_pos[j-1];
            end

            for (int d = 0; d < 6; d++) begin
                r_rat[d] <= n_rat[d];
                r_t[d]   <= mul_p[thse_pkg::MI_L2+d];
                r_s[d]   <= sub_r[d].val;
            end

            for (int i = 0; i < 3; i++) begin
                r_v1[i] <= add1[i].val;
                r_p3[i] <= mul_p[thse_pkg::MI_L4+3*i+2];
                r_v[i]  <= add2[i].val;
            end
            r_e1 <= e1_r.val;
            r_e2 <= mul_p[thse_pkg::MI_L5+2];
            r_en <= e2_r.val;

            for (int d = 0; d < 6; d++) begin
                r_mdl[thse_pkg::ST_L3+1][d] <= mul_p[thse_pkg::MI_L3+d];
            end
            for (int s = thse_pkg::ST_L3 + 2; s <= SL; s++) begin
                r_mdl[s] <= r_mdl[s-1];
            end
        end
    end

endmodule

/* src/thse_mul.sv */
// Four-stage saturating Q32.32 multiplier: floor of the exact product, signed 64-bit clamp.
// Depends on thse_pkg.
module thse_mul (
    input  logic           i_clk,
    input  logic           i_en,
    input  thse_pkg::t_q64 i_x,
    input  thse_pkg::t_q64 i_y,
    output thse_pkg::t_q64 o_p,
    output logic           o_sat
);

    logic [63:0]  r_a, r_b;
    logic         r_neg1, r_neg2, r_neg3;
    logic [63:0]  r_ll, r_m1, r_m2, r_hh;
    logic [127:0] r_prod;
    logic         hiov, rnd;
    logic [63:0]  q;
    logic [63:0]  n_p;
    logic         n_sat;

    always_comb begin
        hiov = |r_prod[127:96];
        q    = r_prod[95:32];
        rnd  = |r_prod[31:0];
        if (!r_neg3) begin
            n_sat = hiov | q[63];
            n_p   = n_sat ? thse_pkg::Q_MAX : q;
        end else begin
            n_sat = hiov | (q[63] & ((|q[62:0]) | rnd));
            n_p   = (hiov | q[63]) ? thse_pkg::Q_MIN : 64'(-(q + 64'(rnd)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= i_x[63] ? 64'(-i_x) : i_x;
            r_b    <= i_y[63] ? 64'(-i_y) : i_y;
            r_neg1 <= i_x[63] ^ i_y[63];
            r_ll   <= r_a[31:0] * r_b[31:0];
            r_m1   <= r_a[63:32] * r_b[31:0];
            r_m2   <= r_a[31:0] * r_b[63:32];
            r_hh   <= r_a[63:32] * r_b[63:32];
            r_neg2 <= r_neg1;
            r_prod <= {r_hh, 64'd0} + {32'd0, r_m1, 32'd0} + {32'd0, r_m2, 32'd0}
                      + {64'd0, r_ll};
            r_neg3 <= r_neg2;
            o_p    <= n_p;
            o_sat  <= n_sat;
        end
    end

endmodule

/* src/thse_chk.sv */
// Port-level checker for the triangle strain energy block, bound to the top level.
// Depends on nothing beyond the top level's ports.
module thse_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [63:0] o_energy,
    input logic signed [63:0] o_m_ij,
    input logic               o_overflow
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_energy) && $stable(o_m_ij) && $stable(o_overflow)))
        else $error("stalled result item changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind triangle_hencky_strain_energy thse_chk u_thse_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_energy    (o_energy),
    .o_m_ij      (o_m_ij),
    .o_overflow  (o_overflow)
);

/* tb/triangle_hencky_strain_energy_tb.sv */
// Self-checking bench for triangle_hencky_strain_energy: faces go in under random bursts,
// results are checked field by field against a saturating Q32.32 predictor.
// Depends on thse_pkg and the block's RTL.
module triangle_hencky_strain_energy_tb;

    localparam int             QSHIFT = thse_pkg::QSHIFT;
    localparam thse_pkg::t_q64 Q_MAX  = thse_pkg::Q_MAX;
    localparam thse_pkg::t_q64 Q_MIN  = thse_pkg::Q_MIN;
    localparam thse_pkg::t_q64 Q_FOUR = thse_pkg::Q_FOUR;
    localparam thse_pkg::t_q64 Q_TWO  = thse_pkg::Q_TWO;

    typedef struct {
        logic signed [31:0] area;
        logic [30:0] lij, ljk, lki;
        logic signed [31:0] ci, cj, ck, d0, d1, d2;
    } t_face;

    typedef struct {
        logic signed [63:0] energy, mij, mjk, mki, mi, mj, mk;
        logic ovf;
    } t_strain;

    logic i_clk, i_rst_n, i_cfg_we, i_in_valid, i_out_stall;
    logic [30:0] i_cfg_data;
    logic o_in_stall, o_out_valid, o_overflow;
    logic signed [31:0] i_face_area, i_cot_i, i_cot_j, i_cot_k, i_dll_ij, i_dll_jk, i_dll_ki;
    logic [30:0] i_len_ij, i_len_jk, i_len_ki;
    logic signed [63:0] o_energy, o_m_ij, o_m_jk, o_m_ki, o_m_i, o_m_j, o_m_k;

    t_strain strain_q[$];
    logic [30:0] zero_ratio;
    int errors = 0;
    int cycles = 0;
    bit sat_flag;
    int stall_mode = 0;

    triangle_hencky_strain_energy uut (.*);

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic signed [63:0] qmul(logic signed [63:0] x, logic signed [63:0] y);
        logic signed [127:0] p;
        p = (128'(x) * 128'(y)) >>> 32;
        if (p > 128'sh7FFF_FFFF_FFFF_FFFF) begin
            sat_flag = 1;
            return Q_MAX;
        end
        if (p < -128'sh8000_0000_0000_0000) begin
            sat_flag = 1;
            return Q_MIN;
        end
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] qadd(logic signed [63:0] a, logic signed [63:0] b,
                                                bit neg_b);
        logic signed [65:0] s;
        s = neg_b ? 66'(a) - 66'(b) : 66'(a) + 66'(b);
        if (s > 66'sh7FFF_FFFF_FFFF_FFFF) begin
            sat_flag = 1;
            return Q_MAX;
        end
        if (s < -66'sh8000_0000_0000_0000) begin
            sat_flag = 1;
            return Q_MIN;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] widen(logic signed [31:0] v);
        return 64'(v) <<< QSHIFT;
    endfunction

    function automatic logic signed [63:0] ratio(logic [63:0] r);
        if (r > (64'h7FFF_FFFF_FFFF_FFFF >> QSHIFT)) begin
            sat_flag = 1;
            return Q_MAX;
        end
        return r << QSHIFT;
    endfunction

    function automatic logic signed [63:0] hencky_entry(logic signed [63:0] a,
            logic signed [63:0] r, logic signed [63:0] s);
        return qmul(qmul(a, qmul(r, r)), s);
    endfunction

    function automatic t_strain predict_strain(t_face f);
        t_strain o;
        logic signed [63:0] a, ci, cj, ck, d0, d1, d2, rij, rjk, rki, ri, rj, rk, v0, v1, v2;
        logic [63:0] den;
        sat_flag = 0;
        a = widen(f.area);
        ci = widen(f.ci); cj = widen(f.cj); ck = widen(f.ck);
        d0 = widen(f.d0); d1 = widen(f.d1); d2 = widen(f.d2);
        if (f.area > 0) begin
            den = 64'(f.area) * 2;
            rij = ratio((64'(f.lij) * f.lij) / den);
            rjk = ratio((64'(f.ljk) * f.ljk) / den);
            rki = ratio((64'(f.lki) * f.lki) / den);
            ri = ratio((64'(f.lij) * f.lki) / den);
            rj = ratio((64'(f.ljk) * f.lij) / den);
            rk = ratio((64'(f.lki) * f.ljk) / den);
        end else begin
            rij = ratio(64'(zero_ratio));
            rjk = rij; rki = rij; ri = rij; rj = rij; rk = rij;
        end
        o.mij = hencky_entry(a, rij, qadd(qmul(Q_FOUR, qmul(rk, rk)), Q_TWO, 1));
        o.mjk = hencky_entry(a, rjk, qadd(qmul(Q_FOUR, qmul(ri, ri)), Q_TWO, 1));
        o.mki = hencky_entry(a, rki, qadd(qmul(Q_FOUR, qmul(rj, rj)), Q_TWO, 1));
        o.mi = hencky_entry(a, ri, qadd(qmul(qmul(Q_FOUR, cj), ck), Q_TWO, 1));
        o.mj = hencky_entry(a, rj, qadd(qmul(qmul(Q_FOUR, ck), ci), Q_TWO, 1));
        o.mk = hencky_entry(a, rk, qadd(qmul(qmul(Q_FOUR, ci), cj), Q_TWO, 1));
        v0 = qadd(qadd(qmul(o.mij, d0), qmul(o.mj, d1), 0), qmul(o.mi, d2), 0);
        v1 = qadd(qadd(qmul(o.mj, d0), qmul(o.mjk, d1), 0), qmul(o.mk, d2), 0);
        v2 = qadd(qadd(qmul(o.mi, d0), qmul(o.mk, d1), 0), qmul(o.mki, d2), 0);
        o.energy = qadd(qadd(qmul(d0, v0), qmul(d1, v1), 0), qmul(d2, v2), 0);
        o.ovf = sat_flag;
        return o;
    endfunction

    task automatic report(string what, logic signed [63:0] got, logic signed [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task automatic send_face(t_face f);
        i_face_area <= f.area;
        i_len_ij <= f.lij; i_len_jk <= f.ljk; i_len_ki <= f.lki;
        i_cot_i <= f.ci; i_cot_j <= f.cj; i_cot_k <= f.ck;
        i_dll_ij <= f.d0; i_dll_jk <= f.d1; i_dll_ki <= f.d2;
        i_in_valid <= 1;
        strain_q = {strain_q, predict_strain(f)};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (strain_q.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic write_ratio(logic [30:0] v);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        zero_ratio = v;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [31:0] rnd_q(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000);
            default: return 32'($signed($urandom_range(0, 32'h600)) - 32'sh300);
        endcase
    endfunction

    function automatic t_face rnd_face();
        t_face f;
        int m;
        m = $urandom_range(0, 2);
        f.area = ($urandom_range(0, 9) == 0) ? -$signed(rnd_q(2) & 32'hFFF) : rnd_q(m);
        if ($urandom_range(0, 9) == 0) f.area = 0;
        if (m != 0 && f.area <= 0 && $urandom_range(0, 1)) f.area = 32'sh8000;
        f.lij = 31'(rnd_q(m)); f.ljk = 31'(rnd_q(m)); f.lki = 31'(rnd_q(m));
        f.ci = rnd_q(m); f.cj = rnd_q(m); f.ck = rnd_q(m);
        f.d0 = rnd_q(m); f.d1 = rnd_q(m); f.d2 = rnd_q(m);
        return f;
    endfunction

    task automatic test_directed();
        t_face f;
        f = '{32'sh1_0000, 31'h1_0000, 31'h1_0000, 31'h1_0000,
              32'sh9_3CD, 32'sh9_3CD, 32'sh9_3CD, 32'sh1_0000, -32'sh8000, 32'sh4000};
        send_face(f);
        f.area = 0; send_face(f);
        f.area = 32'sh8000_0000; send_face(f);
        f.area = 32'sh7FFF_FFFF; send_face(f);
        f.area = 1; send_face(f);
        f.lij = 31'h7FFF_FFFF; f.ljk = 0; send_face(f);
        f.lki = 31'h7FFF_FFFF; f.ljk = 31'h7FFF_FFFF; send_face(f);
        f = '{32'sh2_0000, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7FFF_FFFF, -1};
        send_face(f);
        f.area = -1; send_face(f);
        f = '{32'sh4_0000, 31'h2_0000, 31'h3_0000, 31'h2_8000, 32'sh1_0000, 32'sh0,
              -32'sh1_0000, 0, 0, 0};
        send_face(f);
        drain();
    endtask

    task automatic test_zero_ratio();
        t_face f;
        logic [30:0] vals[4];
        vals = '{31'd0, 31'd1, 31'h1_0000, 31'h7FFF_FFFF};
        foreach (vals[n]) begin
            write_ratio(vals[n]);
            repeat (4) begin
                f = rnd_face();
                f.area = ($urandom_range(0, 1)) ? 0 : -$signed(32'($urandom_range(1, 99)));
                send_face(f);
            end
            drain();
        end
        write_ratio(31'($urandom));
    endtask

    task automatic test_random(int count);
        repeat (count) begin
            send_face(rnd_face());
            if ($urandom_range(0, 15) == 0) stall_mode = $urandom_range(0, 3);
            gap();
        end
        drain();
    endtask

    always @(negedge i_clk) begin
        case (stall_mode)
            0: i_out_stall <= 0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= (cycles % 7) < 3;
            default: i_out_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("triangle_hencky_strain_energy_tb NOT OK");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (strain_q.size() == 0) begin
                report("unexpected item", o_energy, 0);
            end else begin
                t_strain w;
                w = strain_q.pop_front();
                if (o_energy !== w.energy) report("energy", o_energy, w.energy);
                if (o_m_ij !== w.mij) report("m_ij", o_m_ij, w.mij);
                if (o_m_jk !== w.mjk) report("m_jk", o_m_jk, w.mjk);
                if (o_m_ki !== w.mki) report("m_ki", o_m_ki, w.mki);
                if (o_m_i !== w.mi) report("m_i", o_m_i, w.mi);
                if (o_m_j !== w.mj) report("m_j", o_m_j, w.mj);
                if (o_m_k !== w.mk) report("m_k", o_m_k, w.mk);
                if (o_overflow !== w.ovf) report("overflow", o_overflow, w.ovf);
            end
        end
    end

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_data = 0; i_in_valid = 0; i_out_stall = 0;
        i_face_area = 0; i_len_ij = 0; i_len_jk = 0; i_len_ki = 0;
        i_cot_i = 0; i_cot_j = 0; i_cot_k = 0; i_dll_ij = 0; i_dll_jk = 0; i_dll_ki = 0;
        zero_ratio = 31'h7FFF_FFFF;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);
        test_directed();
        test_zero_ratio();
        test_random(1600);
        if (errors == 0) begin
            $display("triangle_hencky_strain_energy_tb OK");
        end else begin
            $display("triangle_hencky_strain_energy_tb NOT OK");
        end
        $finish;
    end
endmodule
